// ===== rtl/sacr_pkg.sv =====
// shared constants, types and state codes for the set-associative cache
package sacr_pkg;

	localparam int MAX_SETS      = 256;
	localparam int MAX_WAYS      = 4;
	localparam int ADDR_W        = 32;
	localparam int SET_W         = $clog2(MAX_SETS);
	localparam int WAY_W         = $clog2(MAX_WAYS);
	localparam int MAX_WAYS_LOG2 = $clog2(MAX_WAYS);
	localparam int CNT_W         = 16;
	localparam int WLOG_W        = 2;
	localparam int CFG_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int DSR_W         = SET_W + 1;
	localparam int DIV_CNT_W     = $clog2(ADDR_W);

	localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SETS_IN_USE = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] SETS_RESET = CFG_W'(MAX_SETS);
	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic [MAX_WAYS-1:0][ADDR_W-1:0]  lines;
	} row_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [SET_W-1:0] set;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/sacr_rem.sv =====
// iterative restoring remainder of a line address by the set count, one bit a cycle
module sacr_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sacr_pkg::ADDR_W-1:0]   dividend,
	input  logic [sacr_pkg::DSR_W-1:0]    divisor,
	output logic                          done,
	output logic [sacr_pkg::SET_W-1:0]    remainder
);
	import sacr_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    dvd_q;
	logic [DSR_W-1:0]     dsr_q;
	logic [SET_W-1:0]     rem_q;
	logic [DSR_W-1:0]     trial;
	logic [DSR_W-1:0]     diff;
	logic [SET_W-1:0]     rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[ADDR_W-1]};
		diff    = trial - dsr_q;
		rem_nxt = (trial >= dsr_q) ? diff[SET_W-1:0] : trial[SET_W-1:0];
	end

	assign done      = busy_q && (cnt_q == DIV_CNT_W'(ADDR_W - 1));
	assign remainder = rem_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ADDR_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

endmodule

// ===== rtl/sacr_store.sv =====
// set memory: one row per set with all ways and the miss count, cleared by row valid bits
module sacr_store (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sacr_pkg::store_req_t req,
	input  sacr_pkg::row_t       wr_row,
	output sacr_pkg::row_t       rd_row
);
	import sacr_pkg::*;

	row_t                mem [MAX_SETS];
	logic [MAX_SETS-1:0] valid_q;
	logic                rd_valid_q;
	row_t                rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.set] <= wr_row;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.set] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.set];
			end
		end
	end

	assign rd_row = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/set_assoc_cache_random_replace.sv =====
// top level of the set-associative cache with random replacement
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+------------------------------------------------
//  request  | in_valid  | in_stall  | line_address, victim_pick
//  result   | out_valid | out_stall | miss, compulsory, way_used, set_index,
//           |           |           | set_miss_count, bad_address
//  config   | cfg_we    | -         | cfg_index, cfg_data
//
//  a request passes from accept to result through the bit-serial set remainder, the memory
//  read, the compare and write back, and the load of the output register
//  a zero address skips the remainder
//  reset returns the configuration to its defaults and clears the per-set valid bits; no clearing pass is needed
//  a new request is taken once the previous one has moved to the output register,
//  and a stalled result holds the next one in its finish state
module set_assoc_cache_random_replace (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sacr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacr_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sacr_pkg::ADDR_W-1:0]       line_address,
	input  logic [sacr_pkg::WAY_W-1:0]        victim_pick,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              miss,
	output logic                              compulsory,
	output logic [sacr_pkg::WAY_W-1:0]        way_used,
	output logic [sacr_pkg::SET_W-1:0]        set_index,
	output logic [sacr_pkg::CNT_W-1:0]        set_miss_count,
	output logic                              bad_address
);
	import sacr_pkg::*;

	state_t state_q, state_nxt;

	logic [WLOG_W-1:0] ways_log2_q;
	logic [CFG_W-1:0]  sets_in_use_q;

	logic [ADDR_W-1:0] addr_q;
	logic [WAY_W-1:0]  pick_q;
	logic              bad_q;
	logic [SET_W-1:0]  set_q;

	logic              res_miss_q;
	logic              res_comp_q;
	logic [WAY_W-1:0]  res_way_q;
	logic [SET_W-1:0]  res_set_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              res_bad_q;
	logic              out_valid_q;

	logic              in_accept;
	logic              addr_zero;
	logic              div_start;
	logic              div_done;
	logic [SET_W-1:0]  div_rem;
	logic [DSR_W-1:0]  divisor;
	logic              out_load;
	logic              check;
	logic              read_en;

	logic [WLOG_W-1:0] lg;
	logic [WAY_W:0]    ways_n;
	logic [WAY_W-1:0]  way_mask;
	logic              found;
	logic              hit;
	logic              comp;
	logic [WAY_W-1:0]  way;
	logic [CNT_W-1:0]  cnt_new;

	store_req_t        store_req;
	row_t              rd_row;
	row_t              wr_row;

	assign in_accept = in_valid && !in_stall;
	assign addr_zero = (line_address == '0);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q   <= '0;
			sets_in_use_q <= SETS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAYS_LOG2:   ways_log2_q   <= cfg_data[WLOG_W-1:0];
				REG_SETS_IN_USE: sets_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (sets_in_use_q == '0) begin
			divisor = DSR_W'(1);
		end else if (sets_in_use_q > CFG_W'(MAX_SETS)) begin
			divisor = DSR_W'(MAX_SETS);
		end else begin
			divisor = DSR_W'(sets_in_use_q);
		end
	end

	sacr_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (line_address),
		.divisor   (divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = addr_zero ? ST_READ : ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ:  state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		read_en   = 1'b0;
		check     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && !addr_zero;
			end
			ST_DIVIDE: ;
			ST_READ:   read_en = 1'b1;
			ST_CHECK:  check = 1'b1;
			ST_FINISH: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture and set index
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_q <= line_address;
			pick_q <= victim_pick;
			bad_q  <= addr_zero;
			if (addr_zero) begin
				set_q <= '0;
			end
		end else if (div_done) begin
			set_q <= div_rem;
		end
	end

	// way search over the row read from the set memory
	always_comb begin
		lg       = (ways_log2_q > WLOG_W'(MAX_WAYS_LOG2)) ? WLOG_W'(MAX_WAYS_LOG2) : ways_log2_q;
		ways_n   = (WAY_W+1)'(1) << lg;
		way_mask = WAY_W'(ways_n - (WAY_W+1)'(1));
		found    = 1'b0;
		hit      = 1'b0;
		comp     = 1'b0;
		way      = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!found && (w < int'(ways_n))) begin
				if (rd_row.lines[w] == addr_q) begin
					found = 1'b1;
					hit   = 1'b1;
					way   = WAY_W'(w);
				end else if (rd_row.lines[w] == '0) begin
					found = 1'b1;
					comp  = 1'b1;
					way   = WAY_W'(w);
				end
			end
		end
		if (!found) begin
			way = pick_q & way_mask;
		end
		cnt_new = (rd_row.count == CNT_MAX) ? rd_row.count : rd_row.count + CNT_W'(1);
	end

	always_comb begin
		wr_row            = rd_row;
		wr_row.lines[way] = addr_q;
		wr_row.count      = cnt_new;
	end

	assign store_req = {read_en, check && !hit && !bad_q, set_q};

	sacr_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.wr_row (wr_row),
		.rd_row (rd_row)
	);

	// result waiting for the output register
	always_ff @(posedge clk) begin
		if (check) begin
			res_bad_q <= bad_q;
			res_set_q <= set_q;
			if (bad_q) begin
				res_miss_q <= 1'b0;
				res_comp_q <= 1'b0;
				res_way_q  <= '0;
				res_cnt_q  <= rd_row.count;
			end else begin
				res_miss_q <= !hit;
				res_comp_q <= comp;
				res_way_q  <= way;
				res_cnt_q  <= hit ? rd_row.count : cnt_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			miss           <= res_miss_q;
			compulsory     <= res_comp_q;
			way_used       <= res_way_q;
			set_index      <= res_set_q;
			set_miss_count <= res_cnt_q;
			bad_address    <= res_bad_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
